/* hw/rtl/srm_pkg.sv */
// types, codes and constants shared by the spi register access master
// no dependencies
package srm_pkg;

    localparam int IN_TDATA_W  = 24;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 16;
    localparam int FRAME_W     = 24;
    localparam int QUEUE_DEPTH = 2;

    // bit 7 of the high address byte marks a read
    localparam logic [7:0] READ_FLAG = 8'h80;

    // byte positions inside a transaction
    localparam logic [1:0] LOAD_BYTE = 2'd2;
    localparam logic [1:0] LAST_BYTE = 2'd3;
    localparam logic [2:0] LAST_BIT  = 3'd7;

    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_NONE  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        STEP_IDLE    = 2'd0,
        STEP_SHIFT   = 2'd1,
        STEP_LOAD_HI = 2'd2,
        STEP_LOAD_LO = 2'd3
    } t_step;

    // classified word handed from front to back
    typedef struct packed {
        t_func                func;
        logic [FRAME_W-1:0]   frame;
        logic                 miso;
    } t_cmd;

    // result word, first member in the highest bits so sclk lands at bit 0
    typedef struct packed {
        logic [7:0] read_data;
        logic       done;
        logic       busy;
        logic       load;
        logic       mosi;
        logic       sclk;
    } t_result;

endpackage

/* hw/rtl/srm_front.sv */
// front end: takes input words, decodes the function and builds the frame
// depends on srm_pkg
module srm_front (
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [srm_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic [srm_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                            o_push_valid,
    input  logic                            i_push_ready,
    output srm_pkg::t_cmd                   o_push_cmd
);

    logic [6:0]     w_addr_hi;
    logic [7:0]     w_addr_lo;
    logic [7:0]     w_wr_value;
    logic           w_miso;
    srm_pkg::t_func w_func;

    assign w_addr_hi  = s_axis_tdata[6:0];
    assign w_addr_lo  = s_axis_tdata[14:7];
    assign w_wr_value = s_axis_tdata[22:15];
    assign w_miso     = s_axis_tdata[23];
    assign w_func     = srm_pkg::t_func'(s_axis_tuser);

    always_comb begin
        o_push_cmd.func = w_func;
        o_push_cmd.miso = w_miso;
        case (w_func)
            srm_pkg::FUNC_READ: begin
                o_push_cmd.frame = {({1'b0, w_addr_hi} | srm_pkg::READ_FLAG), w_addr_lo, 8'h00};
            end
            default: begin
                o_push_cmd.frame = {1'b0, w_addr_hi, w_addr_lo, w_wr_value};
            end
        endcase
    end

    assign o_push_valid  = s_axis_tvalid;
    assign s_axis_tready = i_push_ready;

endmodule

/* hw/rtl/srm_queue.sv */
// short first-in first-out queue between the front and back ends
// no dependencies
module srm_queue #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output logic [WIDTH-1:0] o_pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_push, w_pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

/* hw/rtl/srm_back.sv */
// back end: spi transaction sequencer and result register
// depends on srm_pkg
module srm_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    output logic                o_cmd_ready,
    input  srm_pkg::t_cmd       i_cmd,
    output logic                o_res_valid,
    input  logic                i_res_ready,
    output srm_pkg::t_result    o_res
);

    srm_pkg::t_step r_step, n_step;
    logic [1:0]     r_byte, n_byte;
    logic [2:0]     r_bit, n_bit;
    logic           r_phase, n_phase;
    logic           r_is_read, n_is_read;
    logic [23:0]    r_frame, n_frame;
    logic [7:0]     r_capture, n_capture;
    logic           r_load, n_load;
    logic           r_mosi, n_mosi;
    logic [7:0]     r_last_read, n_last_read;
    logic           n_done;
    logic           r_res_valid;
    srm_pkg::t_result r_res;

    logic           w_step;
    logic           w_bit_last;
    logic [1:0]     w_byte_rev;
    logic [4:0]     w_sh;

    // slot free when the result register is empty or being drained
    assign o_cmd_ready = !r_res_valid || i_res_ready;
    assign w_step      = i_cmd_valid && o_cmd_ready;
    assign w_bit_last  = (r_bit == srm_pkg::LAST_BIT);
    assign w_byte_rev  = srm_pkg::LOAD_BYTE - r_byte;
    assign w_sh        = {w_byte_rev, ~r_bit};

    always_comb begin : next_step
        n_step = r_step;
        case (i_cmd.func)
            srm_pkg::FUNC_TICK: begin
                case (r_step)
                    srm_pkg::STEP_SHIFT: begin
                        if (!r_phase && w_bit_last) begin
                            if (r_byte == srm_pkg::LOAD_BYTE) begin
                                n_step = srm_pkg::STEP_LOAD_HI;
                            end else if (r_byte == srm_pkg::LAST_BYTE) begin
                                n_step = srm_pkg::STEP_IDLE;
                            end
                        end
                    end
                    srm_pkg::STEP_LOAD_HI: begin
                        n_step = srm_pkg::STEP_LOAD_LO;
                    end
                    srm_pkg::STEP_LOAD_LO: begin
                        n_step = r_is_read ? srm_pkg::STEP_SHIFT : srm_pkg::STEP_IDLE;
                    end
                    default: begin
                    end
                endcase
            end
            srm_pkg::FUNC_WRITE, srm_pkg::FUNC_READ: begin
                if (r_step == srm_pkg::STEP_IDLE) begin
                    n_step = srm_pkg::STEP_SHIFT;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin : datapath
        n_byte      = r_byte;
        n_bit       = r_bit;
        n_phase     = r_phase;
        n_is_read   = r_is_read;
        n_frame     = r_frame;
        n_capture   = r_capture;
        n_load      = r_load;
        n_mosi      = r_mosi;
        n_last_read = r_last_read;
        n_done      = 1'b0;
        case (i_cmd.func)
            srm_pkg::FUNC_TICK: begin
                case (r_step)
                    srm_pkg::STEP_SHIFT: begin
                        if (r_phase) begin
                            // low phase: drive frame data, or in the last byte drive zero and sample miso
                            n_phase = 1'b0;
                            if (r_byte != srm_pkg::LAST_BYTE) begin
                                n_mosi = r_frame[w_sh];
                            end else begin
                                n_mosi = 1'b0;
                                if (i_cmd.miso) begin
                                    n_capture[~r_bit] = 1'b1;
                                end
                            end
                        end else begin
                            // high phase: raise clock, advance bit
                            n_phase = 1'b1;
                            if (w_bit_last) begin
                                n_bit = '0;
                                if (r_byte == srm_pkg::LAST_BYTE) begin
                                    n_last_read = r_capture;
                                    n_done      = 1'b1;
                                end else if (r_byte != srm_pkg::LOAD_BYTE) begin
                                    n_byte = r_byte + 1'b1;
                                end
                            end else begin
                                n_bit = r_bit + 1'b1;
                            end
                        end
                    end
                    srm_pkg::STEP_LOAD_HI: begin
                        n_load = 1'b1;
                    end
                    srm_pkg::STEP_LOAD_LO: begin
                        n_load = 1'b0;
                        if (r_is_read) begin
                            n_byte    = srm_pkg::LAST_BYTE;
                            n_bit     = '0;
                            n_capture = '0;
                        end else begin
                            n_done = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            srm_pkg::FUNC_WRITE, srm_pkg::FUNC_READ: begin
                if (r_step == srm_pkg::STEP_IDLE) begin
                    n_is_read = (i_cmd.func == srm_pkg::FUNC_READ);
                    n_frame   = i_cmd.frame;
                    n_byte    = '0;
                    n_bit     = '0;
                    n_phase   = 1'b1;
                    n_capture = '0;
                    n_load    = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= srm_pkg::STEP_IDLE;
            r_byte      <= '0;
            r_bit       <= '0;
            r_phase     <= 1'b1;
            r_is_read   <= 1'b0;
            r_capture   <= '0;
            r_load      <= 1'b1;
            r_mosi      <= 1'b0;
            r_last_read <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (w_step) begin
                r_step      <= n_step;
                r_byte      <= n_byte;
                r_bit       <= n_bit;
                r_phase     <= n_phase;
                r_is_read   <= n_is_read;
                r_capture   <= n_capture;
                r_load      <= n_load;
                r_mosi      <= n_mosi;
                r_last_read <= n_last_read;
            end
            if (o_cmd_ready) begin
                r_res_valid <= i_cmd_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_frame           <= n_frame;
            r_res.sclk        <= n_phase;
            r_res.mosi        <= n_mosi;
            r_res.load        <= n_load;
            r_res.busy        <= (n_step != srm_pkg::STEP_IDLE);
            r_res.done        <= n_done;
            r_res.read_data   <= n_last_read;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

/* hw/rtl/spi_register_access_master.sv */
// an accepted word is held in the queue, and its result is registered in the result register
// throughput: one word per cycle while the output is not stalled; the back end sequencer steps once per word
// and the queue plus result register let input and output stall on their own
// reset: synchronous, active low; sclk and load idle high, mosi and read data
// clear to zero, queue empties
// depends on srm_pkg, srm_front, srm_queue, srm_back
module spi_register_access_master #(
    parameter int QUEUE_DEPTH = srm_pkg::QUEUE_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input words
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // addr_hi[6:0], addr_lo[14:7], wr_value[22:15], miso[23]
    input  logic [srm_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // func[1:0]: tick, start write, start read, none
    input  logic [srm_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
    // result words
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // sclk[0], mosi[1], load[2], busy_res[3], done_res[4], read_data[12:5], zeros above
    output logic [srm_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    localparam int CMD_W = $bits(srm_pkg::t_cmd);

    // front to queue
    logic             w_push_valid;
    logic             w_push_ready;
    srm_pkg::t_cmd    w_push_cmd;

    // queue to back
    logic             w_pop_valid;
    logic             w_pop_ready;
    logic [CMD_W-1:0] w_pop_bits;
    srm_pkg::t_cmd    w_pop_cmd;

    srm_pkg::t_result w_res;

    // front end decodes func and prepares the 24-bit shift frame
    srm_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_push_valid  (w_push_valid),
        .i_push_ready  (w_push_ready),
        .o_push_cmd    (w_push_cmd)
    );

    // queue decouples the input side from the sequencer
    srm_queue #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (CMD_W)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_data  (w_push_cmd),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_data   (w_pop_bits)
    );

    assign w_pop_cmd = srm_pkg::t_cmd'(w_pop_bits);

    // back end runs the spi sequence one half-bit phase per tick word
    srm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_pop_valid),
        .o_cmd_ready (w_pop_ready),
        .i_cmd       (w_pop_cmd),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_res       (w_res)
    );

    assign m_axis_tdata = srm_pkg::OUT_TDATA_W'(w_res);

    // a finishing word always shows the sequencer back at idle
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[4]) |-> !m_axis_tdata[3])
        else $error("done word still reports busy");

    // serial clock rests high whenever no transaction runs
    a_idle_sclk_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[3]) |-> m_axis_tdata[0])
        else $error("sclk low while idle");

    // read data only moves on a word that finishes a transaction
    a_read_data_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(m_axis_tvalid) && m_axis_tvalid
            && (m_axis_tdata[12:5] != $past(m_axis_tdata[12:5]))) |-> m_axis_tdata[4])
        else $error("read data changed without done");

    // a queued word reaches the sequencer whenever the result slot is free
    a_back_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop_valid && !m_axis_tvalid) |=> m_axis_tvalid)
        else $error("back end failed to take a queued word");

endmodule
